// ===== src/hill_pkg.sv =====
package hill_pkg;

    localparam int MODULUS  = 27;
    localparam int SYM_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int KEY_W    = 15;
    localparam int DIM      = 3;
    localparam int KEY_N    = DIM * DIM;
    localparam int ACC_W    = 12;
    // Keeps the adjugate difference non-negative before reduction.
    localparam int ADJ_BIAS = MODULUS * (MODULUS - 1);
    // floor(2^16 / 27); the estimate it gives is short by at most one.
    localparam int RECIP_27 = 2427;

    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [KEY_W-1:0]  key_row_t;
    typedef logic [1:0]        cfg_idx_t;

    localparam cfg_idx_t CFG_KEY_ROW0 = 2'd0;
    localparam cfg_idx_t CFG_KEY_ROW1 = 2'd1;
    localparam cfg_idx_t CFG_KEY_ROW2 = 2'd2;

    localparam key_row_t KEY_ROW0_RESET = 15'd1;
    localparam key_row_t KEY_ROW1_RESET = 15'd32;
    localparam key_row_t KEY_ROW2_RESET = 15'd1024;

    localparam sym_t  SPACE_SYM   = 5'd26;
    localparam char_t ASCII_A     = 8'h61;
    localparam char_t ASCII_Z     = 8'h7a;
    localparam char_t ASCII_SPACE = 8'h20;

    function automatic sym_t mod27(input logic [ACC_W-1:0] v);
        logic [2*ACC_W-1:0] prod;
        logic [ACC_W-1:0]   q;
        logic [ACC_W-1:0]   r;
        prod = (2*ACC_W)'(v) * (2*ACC_W)'(RECIP_27);
        q    = ACC_W'(prod[2*ACC_W-1:16]);
        r    = v - ACC_W'(q * ACC_W'(MODULUS));
        if (r >= ACC_W'(MODULUS)) begin
            r = r - ACC_W'(MODULUS);
        end
        return r[SYM_W-1:0];
    endfunction

    // Key entries 27..31 act as 0..4.
    function automatic sym_t key_entry(input logic [SYM_W-1:0] e);
        return (e >= SYM_W'(MODULUS)) ? sym_t'(e - SYM_W'(MODULUS)) : e;
    endfunction

    function automatic sym_t inv_mod27(input sym_t d);
        sym_t r;
        case (d)
            5'd1:    r = 5'd1;
            5'd2:    r = 5'd14;
            5'd4:    r = 5'd7;
            5'd5:    r = 5'd11;
            5'd7:    r = 5'd4;
            5'd8:    r = 5'd17;
            5'd10:   r = 5'd19;
            5'd11:   r = 5'd5;
            5'd13:   r = 5'd25;
            5'd14:   r = 5'd2;
            5'd16:   r = 5'd22;
            5'd17:   r = 5'd8;
            5'd19:   r = 5'd10;
            5'd20:   r = 5'd23;
            5'd22:   r = 5'd16;
            5'd23:   r = 5'd20;
            5'd25:   r = 5'd13;
            5'd26:   r = 5'd26;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic sym_t sym_of(input char_t ch);
        if (ch >= ASCII_A && ch <= ASCII_Z) begin
            return sym_t'(ch - ASCII_A);
        end
        return SPACE_SYM;
    endfunction

    function automatic char_t ascii_of(input sym_t y);
        return (y < SPACE_SYM) ? char_t'(ASCII_A + char_t'(y)) : ASCII_SPACE;
    endfunction

endpackage

// ===== src/hill_cipher_3x3_decrypt_mod27_core.sv =====
// Hill 3x3 decryption mod 27: one input byte accepted per cycle when unstalled.
// A group-closing byte yields three output bytes, the first in the cycle after
// acceptance, then one per cycle while m_ready is high; a full-group stream keeps
// that rate as the three-entry output shift register drains while the next group
// fills. A key write blocks input while the inverse pipeline settles. aresetn
// (synchronous, active low) restores the identity key and clears the counters.
module hill_cipher_3x3_decrypt_mod27_core (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  hill_pkg::cfg_idx_t       cfg_index,
    input  hill_pkg::key_row_t       cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  hill_pkg::char_t          s_char_in,
    input  logic                     s_last_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output hill_pkg::char_t          m_char_out,
    output logic                     m_last_in_group,
    output logic                     m_end_of_message,
    output logic                     m_key_singular
);

    localparam int N   = hill_pkg::KEY_N;
    localparam int D   = hill_pkg::DIM;
    localparam int AW  = hill_pkg::ACC_W;

    // Key and inverse pipeline
    hill_pkg::key_row_t key_row_reg [D];
    hill_pkg::sym_t     kmod_reg    [N];
    hill_pkg::sym_t     kmod_next   [N];
    hill_pkg::sym_t     adjm_reg    [N];
    hill_pkg::sym_t     adjm_next   [N];
    hill_pkg::sym_t     inv_det_reg;
    hill_pkg::sym_t     inv_det_next;
    logic               singular_reg;
    hill_pkg::sym_t     inv_reg     [N];
    hill_pkg::sym_t     inv_next    [N];
    logic [2:0]         upd_cnt_reg;

    // Group assembly and output shift register
    logic [1:0]         fill_reg;
    hill_pkg::sym_t     held_reg    [2];
    hill_pkg::sym_t     out_sym_reg [D];
    logic [1:0]         out_cnt_reg;
    logic               out_eom_reg;
    logic               out_sing_reg;

    hill_pkg::sym_t     sym;
    hill_pkg::sym_t     vec         [D];
    hill_pkg::sym_t     y           [D];
    logic               completing;
    logic               out_free;
    logic               s_fire;
    logic               m_fire;
    logic               load;

    always_comb begin
        int a1, a2, b1, b2;
        logic [AW-1:0] p1, p2;
        for (int r = 0; r < D; r++) begin
            for (int c = 0; c < D; c++) begin
                kmod_next[r*D+c] = hill_pkg::key_entry(key_row_reg[r][5*c +: 5]);
            end
        end
        for (int r = 0; r < D; r++) begin
            for (int c = 0; c < D; c++) begin
                a1 = (c == D-1) ? 0 : c + 1;
                a2 = (c == 0) ? D-1 : c - 1;
                b1 = (r == D-1) ? 0 : r + 1;
                b2 = (r == 0) ? D-1 : r - 1;
                p1 = AW'(kmod_reg[a1*D+b1]) * AW'(kmod_reg[a2*D+b2]);
                p2 = AW'(kmod_reg[a1*D+b2]) * AW'(kmod_reg[a2*D+b1]);
                adjm_next[r*D+c] = hill_pkg::mod27(AW'(p1 + AW'(hill_pkg::ADJ_BIAS) - p2));
            end
        end
    end

    always_comb begin
        logic [AW-1:0] det_sum;
        det_sum = '0;
        for (int c = 0; c < D; c++) begin
            det_sum = AW'(det_sum + AW'(kmod_reg[c]) * AW'(adjm_reg[c*D]));
        end
        inv_det_next = hill_pkg::inv_mod27(hill_pkg::mod27(det_sum));
        for (int i = 0; i < N; i++) begin
            inv_next[i] = hill_pkg::mod27(AW'(inv_det_reg) * AW'(adjm_reg[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_row_reg[0] <= hill_pkg::KEY_ROW0_RESET;
            key_row_reg[1] <= hill_pkg::KEY_ROW1_RESET;
            key_row_reg[2] <= hill_pkg::KEY_ROW2_RESET;
            for (int i = 0; i < N; i++) begin
                kmod_reg[i] <= (i == 0 || i == D+1 || i == N-1) ? 5'd1 : 5'd0;
                adjm_reg[i] <= (i == 0 || i == D+1 || i == N-1) ? 5'd1 : 5'd0;
                inv_reg[i]  <= (i == 0 || i == D+1 || i == N-1) ? 5'd1 : 5'd0;
            end
            inv_det_reg  <= 5'd1;
            singular_reg <= 1'b0;
            upd_cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    hill_pkg::CFG_KEY_ROW0: key_row_reg[0] <= cfg_wdata;
                    hill_pkg::CFG_KEY_ROW1: key_row_reg[1] <= cfg_wdata;
                    hill_pkg::CFG_KEY_ROW2: key_row_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            kmod_reg     <= kmod_next;
            adjm_reg     <= adjm_next;
            inv_det_reg  <= inv_det_next;
            singular_reg <= (inv_det_next == '0);
            inv_reg      <= inv_next;
            // Hold off input until the new key reaches the inverse registers.
            if (cfg_wr_en) begin
                upd_cnt_reg <= 3'd4;
            end else if (upd_cnt_reg != '0) begin
                upd_cnt_reg <= upd_cnt_reg - 3'd1;
            end
        end
    end

    assign sym        = hill_pkg::sym_of(s_char_in);
    assign completing = s_last_in || (fill_reg == 2'd2);
    assign out_free   = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_ready);
    assign s_ready    = (upd_cnt_reg == '0) && (!completing || out_free);
    assign s_fire     = s_valid && s_ready;
    assign m_fire     = m_valid && m_ready;
    assign load       = s_fire && completing;

    always_comb begin
        vec[0] = hill_pkg::SPACE_SYM;
        vec[1] = hill_pkg::SPACE_SYM;
        vec[2] = hill_pkg::SPACE_SYM;
        case (fill_reg)
            2'd0: begin
                vec[0] = sym;
            end
            2'd1: begin
                vec[0] = held_reg[0];
                vec[1] = sym;
            end
            default: begin
                vec[0] = held_reg[0];
                vec[1] = held_reg[1];
                vec[2] = sym;
            end
        endcase
    end

    always_comb begin
        logic [AW-1:0] acc;
        for (int r = 0; r < D; r++) begin
            acc = '0;
            for (int j = 0; j < D; j++) begin
                acc = AW'(acc + AW'(inv_reg[r*D+j]) * AW'(vec[j]));
            end
            y[r] = hill_pkg::mod27(acc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            out_cnt_reg <= '0;
        end else begin
            if (s_fire) begin
                fill_reg <= completing ? 2'd0 : fill_reg + 2'd1;
            end
            if (load) begin
                out_cnt_reg <= 2'd3;
            end else if (m_fire) begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && !completing) begin
            held_reg[fill_reg[0]] <= sym;
        end
        if (load) begin
            out_sym_reg  <= y;
            out_eom_reg  <= s_last_in;
            out_sing_reg <= singular_reg;
        end else if (m_fire) begin
            // advance to the next byte of the group
            out_sym_reg[0] <= out_sym_reg[1];
            out_sym_reg[1] <= out_sym_reg[2];
        end
    end

    assign m_valid          = (out_cnt_reg != 2'd0);
    assign m_char_out       = hill_pkg::ascii_of(out_sym_reg[0]);
    assign m_last_in_group  = (out_cnt_reg == 2'd1);
    assign m_end_of_message = (out_cnt_reg == 2'd1) && out_eom_reg;
    assign m_key_singular   = out_sing_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (out_cnt_reg == 2'd0) || (out_cnt_reg == 2'd1 && m_ready))
        else $error("group loaded while output bytes still pending");

    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (out_cnt_reg == 2'd3) && m_valid)
        else $error("loaded group not presented as three bytes");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_ready ##1 !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("input accepted before inverse key settled");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        singular_reg |=> (inv_reg[0] == '0) && (inv_reg[4] == '0) && (inv_reg[8] == '0))
        else $error("singular key left a nonzero inverse entry");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && completing |=> fill_reg == 2'd0)
        else $error("group fill not cleared after closing byte");
`endif

endmodule
